// ===== rtl/adsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package adsr_pkg;

  localparam int FRACTION_BITS   = 24;
  localparam int ATTACK_LEN_BITS = 20;

  localparam int Q16_UP  = FRACTION_BITS - 16;
  localparam int LEVEL_W = FRACTION_BITS + 1;
  localparam int LEN_W   = ATTACK_LEN_BITS + 1;
  localparam int DIV_CNT_W = $clog2(LEVEL_W);

  // shared multiplier: signed A by signed B
  localparam int MUL_A_W = LEVEL_W + 1;
  localparam int MUL_B_W = 18;
  localparam int MUL_W   = MUL_A_W + MUL_B_W;
  localparam int SHR_W   = LEVEL_W + 16;

  localparam int FUNC_W   = 2;
  localparam int VEL_W    = 17;
  localparam int Q16_W    = 17;
  localparam int COEFF_W  = 16;
  localparam int AS_W     = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [LEVEL_W-1:0] ONE_Q = LEVEL_W'(1) << FRACTION_BITS;
  localparam logic [Q16_W-1:0]   Q16_ONE = Q16_W'(65536);

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK     = 2'd0,
    FN_NOTE_ON  = 2'd1,
    FN_NOTE_OFF = 2'd2
  } adsr_func_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } adsr_phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_RESET = 3'd0,
    CFG_VEL_SENS     = 3'd1,
    CFG_ATTACK_LEN   = 3'd2,
    CFG_DECAY_COEFF  = 3'd3,
    CFG_SUSTAIN      = 3'd4,
    CFG_RELEASE      = 3'd5,
    CFG_FLOOR        = 3'd6
  } adsr_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_SHRINK,
    ST_PUSH,
    ST_NOTE_MUL,
    ST_NOTE_PEAK,
    ST_NOTE_DIV
  } adsr_state_t;

endpackage
`default_nettype wire

// ===== rtl/adsr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface adsr_in_if;
  import adsr_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [VEL_W-1:0]    velocity;

  modport source (output valid, output func, output velocity, input ready);
  modport sink   (input valid, input func, input velocity, output ready);
endinterface
`default_nettype wire

// ===== rtl/adsr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface adsr_out_if;
  import adsr_pkg::*;

  logic              valid;
  logic              ready;
  logic [Q16_W-1:0]  level;
  logic              active;

  modport source (output valid, output level, output active, input ready);
  modport sink   (input valid, input level, input active, output ready);
endinterface
`default_nettype wire

// ===== rtl/adsr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module adsr_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [adsr_pkg::LEVEL_W-1:0] dividend,
  input  wire logic [adsr_pkg::LEN_W-1:0]   divisor,
  output logic      [adsr_pkg::LEVEL_W-1:0] quotient,
  output logic                             done
);
  import adsr_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [LEVEL_W-1:0]   quo_r;
  logic [LEN_W-1:0]     rem_r;
  logic [LEN_W-1:0]     dvs_r;

  logic [LEN_W:0] shifted;
  logic [LEN_W:0] diff;
  logic           take;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_r, quo_r[LEVEL_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    take    = shifted >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(LEVEL_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[LEVEL_W-2:0], take};
      rem_r <= take ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// ===== rtl/adsr_envelope_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sample tick: result beat loaded in ST_PUSH after ST_TICK (and ST_SHRINK for decay/release),
// which holds while the output register is full; input is ready again once it loads. Note on:
// ST_NOTE_MUL, ST_NOTE_PEAK, then the serial attack-step divider, one quotient bit per cycle.
// Note off and unused codes: handled without leaving idle. One item in flight at a time.
// Synchronous active-low reset returns registers to defaults, level 0, phase idle.
module adsr_envelope_generator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  adsr_in_if.sink                             in_ch,
  adsr_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [adsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import adsr_pkg::*;

  // configuration
  logic               attack_reset_r;
  logic [Q16_W-1:0]   vel_sens_r;
  logic [AS_W-1:0]    attack_len_r;
  logic [COEFF_W-1:0] decay_coeff_r;
  logic [Q16_W-1:0]   sustain_r;
  logic [COEFF_W-1:0] release_coeff_r;
  logic [Q16_W-1:0]   floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_reset_r  <= 1'b0;
      vel_sens_r      <= Q16_W'(65536);
      attack_len_r    <= AS_W'(480);
      decay_coeff_r   <= COEFF_W'(1000);
      sustain_r       <= Q16_W'(32768);
      release_coeff_r <= COEFF_W'(1000);
      floor_r         <= Q16_W'(1);
    end else if (cfg_we) begin
      case (adsr_cfg_idx_t'(cfg_index))
        CFG_ATTACK_RESET: attack_reset_r  <= cfg_wdata[0];
        CFG_VEL_SENS:     vel_sens_r      <= cfg_wdata[Q16_W-1:0];
        CFG_ATTACK_LEN:   attack_len_r    <= cfg_wdata[AS_W-1:0];
        CFG_DECAY_COEFF:  decay_coeff_r   <= cfg_wdata[COEFF_W-1:0];
        CFG_SUSTAIN:      sustain_r       <= cfg_wdata[Q16_W-1:0];
        CFG_RELEASE:      release_coeff_r <= cfg_wdata[COEFF_W-1:0];
        CFG_FLOOR:        floor_r         <= cfg_wdata[Q16_W-1:0];
        default: ;
      endcase
    end
  end

  // envelope state and sequencer
  adsr_state_t        state_r, state_nxt;
  adsr_phase_t        phase_r, phase_nxt;
  logic [LEVEL_W-1:0] env_r, env_nxt;
  logic [LEVEL_W-1:0] peak_r, peak_nxt;
  logic [LEVEL_W-1:0] step_r, step_nxt;
  logic [VEL_W-1:0]   vel_r;
  logic signed [MUL_W-1:0] mul_r;
  logic [Q16_W-1:0]   res_level_r, res_level_nxt;
  logic               res_active_r, res_active_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [Q16_W-1:0]   out_level_r;
  logic               out_active_r;
  logic               out_load;

  logic                  in_beat;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_B_W-1:0] vel_delta;

  logic [LEVEL_W-1:0]  sustain_q;
  logic [LEVEL_W-1:0]  floor_q;
  logic [LEVEL_W:0]    attack_sum;
  logic [SHR_W:0]      dec_full;
  logic [LEVEL_W:0]    dec;
  logic [LEVEL_W-1:0]  shrunk;
  logic signed [MUL_W:0] peak_v;
  logic [LEVEL_W-1:0]  peak_calc;
  logic [LEVEL_W-1:0]  env_start;
  logic [LEN_W-1:0]    attack_len;

  logic                div_start;
  logic [LEVEL_W-1:0]  div_q;
  logic                div_done;

  assign in_beat   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign sustain_q = (sustain_r > Q16_ONE) ? (LEVEL_W'(Q16_ONE) << Q16_UP)
                                            : (LEVEL_W'(sustain_r) << Q16_UP);
  assign floor_q   = LEVEL_W'(floor_r) << Q16_UP;

  // shared multiplier: velocity weight on note on, level times coefficient on ticks
  assign vel_delta = $signed({1'b0, vel_r}) - MUL_B_W'(65536);
  always_comb begin
    if (state_r == ST_NOTE_MUL) begin
      mul_a = MUL_A_W'(vel_delta);
      mul_b = $signed({1'b0, vel_sens_r});
    end else begin
      mul_a = $signed({1'b0, env_r});
      mul_b = (phase_r == PH_DECAY) ? $signed({2'b00, decay_coeff_r})
                                    : $signed({2'b00, release_coeff_r});
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // decrement is ceil(level * coeff / 65536)
  always_comb begin
    dec_full = {1'b0, mul_r[SHR_W-1:0]} + (SHR_W+1)'(65535);
    dec      = dec_full[SHR_W:16];
    shrunk   = (dec > {1'b0, env_r}) ? '0 : (env_r - dec[LEVEL_W-1:0]);
  end

  assign attack_sum = {1'b0, env_r} + {1'b0, step_r};

  // peak = 1 + (vel - 1) * sens in Q32, saturated to [0, 1.0]
  always_comb begin
    peak_v = $signed({mul_r[MUL_W-1], mul_r}) + $signed((MUL_W+1)'(64'd1 << 32));
    if (peak_v <= 0)
      peak_calc = '0;
    else if (peak_v >= $signed((MUL_W+1)'(64'd1 << 32)))
      peak_calc = ONE_Q;
    else
      peak_calc = LEVEL_W'(peak_v[31:32-FRACTION_BITS]);
  end

  assign env_start = attack_reset_r ? '0 : env_r;

  always_comb begin
    if (attack_len_r == '0)
      attack_len = LEN_W'(1);
    else if (32'(attack_len_r) > (32'd1 << ATTACK_LEN_BITS))
      attack_len = LEN_W'(32'd1 << ATTACK_LEN_BITS);
    else
      attack_len = LEN_W'(attack_len_r);
  end

  adsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (peak_calc),
    .divisor  (attack_len),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    env_nxt        = env_r;
    peak_nxt       = peak_r;
    step_nxt       = step_r;
    res_level_nxt  = res_level_r;
    res_active_nxt = res_active_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_load       = 1'b0;
    div_start      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          case (adsr_func_t'(in_ch.func))
            FN_TICK: begin
              res_level_nxt  = env_r[LEVEL_W-1:Q16_UP];
              res_active_nxt = (phase_r != PH_IDLE);
              state_nxt      = ST_TICK;
            end
            FN_NOTE_ON:  state_nxt = ST_NOTE_MUL;
            FN_NOTE_OFF: begin
              if (phase_r != PH_IDLE)
                phase_nxt = PH_RELEASE;
            end
            default: ;
          endcase
        end
      end

      ST_TICK: begin
        case (phase_r)
          PH_ATTACK: begin
            if (attack_sum >= {1'b0, peak_r}) begin
              env_nxt   = peak_r;
              phase_nxt = PH_DECAY;
            end else begin
              env_nxt = attack_sum[LEVEL_W-1:0];
            end
            state_nxt = ST_PUSH;
          end
          PH_DECAY, PH_RELEASE: state_nxt = ST_SHRINK;
          PH_SUSTAIN: begin
            env_nxt   = sustain_q;
            state_nxt = ST_PUSH;
          end
          default: begin
            env_nxt   = '0;
            phase_nxt = PH_IDLE;
            state_nxt = ST_PUSH;
          end
        endcase
      end

      ST_SHRINK: begin
        env_nxt = shrunk;
        if (phase_r == PH_DECAY && shrunk <= sustain_q) begin
          env_nxt   = sustain_q;
          phase_nxt = PH_SUSTAIN;
        end
        if (env_nxt <= floor_q)
          phase_nxt = PH_IDLE;
        state_nxt = ST_PUSH;
      end

      ST_PUSH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_NOTE_MUL: state_nxt = ST_NOTE_PEAK;

      ST_NOTE_PEAK: begin
        env_nxt   = env_start;
        peak_nxt  = peak_calc;
        phase_nxt = (env_start < peak_calc) ? PH_ATTACK : PH_DECAY;
        div_start = 1'b1;
        state_nxt = ST_NOTE_DIV;
      end

      ST_NOTE_DIV: begin
        if (div_done) begin
          step_nxt  = (div_q == '0 && peak_r != '0) ? LEVEL_W'(1) : div_q;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      env_r       <= '0;
      peak_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      env_r       <= env_nxt;
      peak_r      <= peak_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat)
      vel_r <= in_ch.velocity;
    res_level_r  <= res_level_nxt;
    res_active_r <= res_active_nxt;
    if (out_load) begin
      out_level_r  <= res_level_r;
      out_active_r <= res_active_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.level  = out_level_r;
  assign out_ch.active = out_active_r;

endmodule
`default_nettype wire
